// ===== rtl/core/octree_node_id_codec_top_macros.svh =====
// Assertion macros for the octree node id codec.
// Included by the top level; depends on nothing else.
`ifndef OCTREE_NODE_ID_CODEC_TOP_MACROS_SVH
`define OCTREE_NODE_ID_CODEC_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define OCNIC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define OCNIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ocnic_pkg.sv =====
// Package for the octree node id codec: field widths, opcodes and item types.
// Used by every module of the block; depends on nothing.
package ocnic_pkg;

    localparam int LEVEL_W         = 5;
    localparam int COORD_W         = 16;
    localparam int ID_W            = 49;
    localparam int FIT_LEVEL       = (ID_W - 1) / 3;
    localparam int DEPTH_LIMIT_DEF = 16;
    localparam int TDATA_W         = 104;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_opcode;

    // Input payload, level in the lowest bits.
    typedef struct packed {
        logic [ID_W-1:0]    packed_id;
        logic [COORD_W-1:0] coord_z;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_x;
        logic [LEVEL_W-1:0] level;
    } t_in_item;

    // Result payload, id in the lowest bits.
    typedef struct packed {
        logic [COORD_W-1:0] out_z;
        logic [COORD_W-1:0] out_y;
        logic [COORD_W-1:0] out_x;
        logic [LEVEL_W-1:0] out_level;
        logic [ID_W-1:0]    out_id;
    } t_out_item;

    // Decoder result handed to the top level.
    typedef struct packed {
        logic               bad;
        logic [LEVEL_W-1:0] level;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
    } t_dec_res;

endpackage

// ===== rtl/core/ocnic_encoder.sv =====
// Encoder of the octree node id codec: interleaves level and coordinates into an id.
// Depends on ocnic_pkg.
module ocnic_encoder #(
    parameter int DEPTH_LIMIT = ocnic_pkg::DEPTH_LIMIT_DEF
) (
    input  logic [ocnic_pkg::LEVEL_W-1:0] i_level,
    input  logic [ocnic_pkg::COORD_W-1:0] i_coord_x,
    input  logic [ocnic_pkg::COORD_W-1:0] i_coord_y,
    input  logic [ocnic_pkg::COORD_W-1:0] i_coord_z,
    output logic [ocnic_pkg::ID_W-1:0]    o_id,
    output logic                          o_bad
);

    localparam int LIMIT = (DEPTH_LIMIT < ocnic_pkg::FIT_LEVEL) ? DEPTH_LIMIT
                                                                 : ocnic_pkg::FIT_LEVEL;

    assign o_bad = (i_level > ocnic_pkg::LEVEL_W'(LIMIT));

    // Triple k carries coordinate bit level-1-k; the sentinel sits at bit 3*level.
    always_comb begin
        logic [ocnic_pkg::LEVEL_W-1:0] b;
        o_id = '0;
        for (int k = 0; k < ocnic_pkg::FIT_LEVEL; k++) begin
            b = i_level - ocnic_pkg::LEVEL_W'(k) - ocnic_pkg::LEVEL_W'(1);
            if (ocnic_pkg::LEVEL_W'(k) < i_level) begin
                o_id[3*k+2] = i_coord_x[b[3:0]];
                o_id[3*k+1] = i_coord_y[b[3:0]];
                o_id[3*k]   = i_coord_z[b[3:0]];
            end
        end
        for (int k = 0; k <= ocnic_pkg::FIT_LEVEL; k++) begin
            if (i_level == ocnic_pkg::LEVEL_W'(k)) begin
                o_id[3*k] = 1'b1;
            end
        end
        if (o_bad) begin
            o_id = '0;
        end
    end

endmodule

// ===== rtl/core/ocnic_decoder.sv =====
// Decoder of the octree node id codec: locates the sentinel and de-interleaves the id.
// Depends on ocnic_pkg.
module ocnic_decoder #(
    parameter int DEPTH_LIMIT = ocnic_pkg::DEPTH_LIMIT_DEF
) (
    input  logic [ocnic_pkg::ID_W-1:0] i_packed_id,
    output ocnic_pkg::t_dec_res        o_res
);

    logic [ocnic_pkg::FIT_LEVEL:0] match;

    // Level l matches if bit 3*l is set, all bits above are clear and l <= DEPTH_LIMIT.
    always_comb begin
        for (int l = 0; l <= ocnic_pkg::FIT_LEVEL; l++) begin
            match[l] = i_packed_id[3*l] && ((i_packed_id >> (3*l + 1)) == '0)
                       && (l <= DEPTH_LIMIT);
        end
    end

    always_comb begin
        o_res = '0;
        for (int l = 0; l <= ocnic_pkg::FIT_LEVEL; l++) begin
            if (match[l]) begin
                o_res.level = o_res.level | ocnic_pkg::LEVEL_W'(l);
                for (int b = 0; b < l; b++) begin
                    o_res.coord_x[b] = o_res.coord_x[b] | i_packed_id[3*(l-1-b)+2];
                    o_res.coord_y[b] = o_res.coord_y[b] | i_packed_id[3*(l-1-b)+1];
                    o_res.coord_z[b] = o_res.coord_z[b] | i_packed_id[3*(l-1-b)];
                end
            end
        end
        o_res.bad = ~|match;
    end

endmodule

// ===== rtl/core/octree_node_id_codec_top.sv =====
// Octree node id codec: converts between (level, x, y, z) and a sentinel-marked node id.
// Depends on ocnic_pkg, ocnic_encoder, ocnic_decoder and the assertion macro header.
//
// Usage:
// The slave channel takes one conversion per item. tuser selects the direction
// (0 encode, 1 decode); tdata carries level, x, y, z and the packed id.
// The master channel returns exactly one result item per input item, in order.
// Its tdata carries id, level and x, y, z; tuser flags a rejected item, whose
// other fields are then all zero.
// An accepted item passes the input register, then the encoder and decoder
// logic, then the result register, which loads when empty or being read.
// Throughput is one item per cycle while results are taken; the input
// register and the result register each hold one item, so a new item is
// taken while a finished result waits.
// When the receiver stalls, the result register holds its item and the input
// register fills; tready drops only when both are full.
// Reset empties both registers; no result is presented until new items arrive.
`include "octree_node_id_codec_top_macros.svh"

module octree_node_id_codec_top #(
    parameter int DEPTH_LIMIT = ocnic_pkg::DEPTH_LIMIT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // level[4:0], coord_x[20:5], coord_y[36:21], coord_z[52:37],
    // packed_id[101:53], zero[103:102]
    input  logic [ocnic_pkg::TDATA_W-1:0] i_s_tdata,
    // opcode[0]
    input  logic [0:0]                    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // out_id[48:0], out_level[53:49], out_x[69:54], out_y[85:70],
    // out_z[101:86], zero[103:102]
    output logic [ocnic_pkg::TDATA_W-1:0] o_m_tdata,
    // bad_item[0]
    output logic [0:0]                    o_m_tuser
);

    localparam int ITEM_W = $bits(ocnic_pkg::t_in_item);
    localparam int RES_W  = $bits(ocnic_pkg::t_out_item);

    logic                 r_in_vld;
    ocnic_pkg::t_opcode   r_in_op;
    ocnic_pkg::t_in_item  r_in_item;
    logic                 r_out_vld;
    ocnic_pkg::t_out_item r_out_item;
    logic                 r_out_bad;
    ocnic_pkg::t_out_item n_out_item;
    logic                 n_out_bad;

    logic                          w_adv;
    logic                          w_s_accept;
    logic [ocnic_pkg::ID_W-1:0]    w_enc_id;
    logic                          w_enc_bad;
    ocnic_pkg::t_dec_res           w_dec;

    assign w_adv      = !r_out_vld || i_m_tready;
    assign o_s_tready = !r_in_vld || w_adv;
    assign w_s_accept = i_s_tvalid && o_s_tready;

    ocnic_encoder #(
        .DEPTH_LIMIT (DEPTH_LIMIT)
    ) u_encoder (
        .i_level   (r_in_item.level),
        .i_coord_x (r_in_item.coord_x),
        .i_coord_y (r_in_item.coord_y),
        .i_coord_z (r_in_item.coord_z),
        .o_id      (w_enc_id),
        .o_bad     (w_enc_bad)
    );

    ocnic_decoder #(
        .DEPTH_LIMIT (DEPTH_LIMIT)
    ) u_decoder (
        .i_packed_id (r_in_item.packed_id),
        .o_res       (w_dec)
    );

    always_comb begin
        n_out_item = '0;
        unique case (r_in_op)
            ocnic_pkg::OP_ENCODE: begin
                n_out_item.out_id = w_enc_id;
                n_out_bad         = w_enc_bad;
            end
            ocnic_pkg::OP_DECODE: begin
                n_out_item.out_level = w_dec.level;
                n_out_item.out_x     = w_dec.coord_x;
                n_out_item.out_y     = w_dec.coord_y;
                n_out_item.out_z     = w_dec.coord_z;
                n_out_bad            = w_dec.bad;
            end
            default: begin
                n_out_bad = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            if (w_adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_in_op   <= ocnic_pkg::t_opcode'(i_s_tuser[0]);
            r_in_item <= ocnic_pkg::t_in_item'(i_s_tdata[ITEM_W-1:0]);
        end
        if (w_adv && r_in_vld) begin
            r_out_item <= n_out_item;
            r_out_bad  <= n_out_bad;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(ocnic_pkg::TDATA_W - RES_W){1'b0}}, r_out_item};
    assign o_m_tuser  = r_out_bad;

    `OCNIC_ASSERT_NOW(a_bad_item_zero, o_m_tvalid && o_m_tuser[0], o_m_tdata == '0, "rejected item carries nonzero fields")
    `OCNIC_ASSERT_NEXT(a_accept_loads, w_s_accept, r_in_vld, "accepted item not held in input register")
    `OCNIC_ASSERT_NEXT(a_item_moves, r_in_vld && w_adv, o_m_tvalid, "item lost between input and result register")

endmodule

// ===== dv/octree_node_id_codec_checker.sv =====
// Result checker for the octree node id codec: predicts each conversion and compares results.
// Watches both stream channels of octree_node_id_codec_top; depends on ocnic_pkg only.
module octree_node_id_codec_checker #(
    parameter int DEPTH_LIMIT = ocnic_pkg::DEPTH_LIMIT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [ocnic_pkg::TDATA_W-1:0] i_s_tdata,
    input  logic [0:0]                    i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [ocnic_pkg::TDATA_W-1:0] i_m_tdata,
    input  logic [0:0]                    i_m_tuser,
    output int                            o_fail_count,
    output int                            o_pending_count,
    output int                            o_rejected_count
);

    localparam int ID_W  = ocnic_pkg::ID_W;
    localparam int IN_W  = $bits(ocnic_pkg::t_in_item);
    localparam int OUT_W = $bits(ocnic_pkg::t_out_item);

    typedef struct packed {
        logic                 rejected;
        ocnic_pkg::t_out_item fields;
    } t_conversion;

    t_conversion conversions[$];

    function automatic t_conversion convert_node(ocnic_pkg::t_opcode op,
                                                 ocnic_pkg::t_in_item it);
        t_conversion res;
        logic [ID_W-1:0] code;
        int top_bit;
        int depth;
        res = '0;
        if (op == ocnic_pkg::OP_ENCODE) begin
            if (it.level > DEPTH_LIMIT || it.level > ocnic_pkg::FIT_LEVEL) begin
                res.rejected = 1'b1;
            end else begin
                code = ID_W'(1);
                for (int l = 0; l < it.level; l++) begin
                    code = {code[ID_W-4:0], it.coord_x[l], it.coord_y[l], it.coord_z[l]};
                end
                res.fields.out_id = code;
            end
        end else begin
            code = it.packed_id;
            top_bit = -1;
            for (int b = 0; b < ID_W; b++) begin
                if (code[b]) top_bit = b;
            end
            if (top_bit < 0 || top_bit % 3 != 0 || top_bit / 3 > DEPTH_LIMIT) begin
                res.rejected = 1'b1;
            end else begin
                depth = top_bit / 3;
                res.fields.out_level = ocnic_pkg::LEVEL_W'(depth);
                for (int k = 0; k < depth; k++) begin
                    res.fields.out_z[depth-1-k] = code[3*k];
                    res.fields.out_y[depth-1-k] = code[3*k+1];
                    res.fields.out_x[depth-1-k] = code[3*k+2];
                end
            end
        end
        return res;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        ocnic_pkg::t_out_item got;
        t_conversion          want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                got = ocnic_pkg::t_out_item'(i_m_tdata[OUT_W-1:0]);
                if (conversions.size() == 0) begin
                    $error("Result item arrived with no conversion outstanding.");
                    o_fail_count++;
                end else begin
                    want = conversions.pop_front();
                    if (want.rejected) o_rejected_count++;
                    check_field("out_id", 64'(want.fields.out_id), 64'(got.out_id));
                    check_field("out_level", 64'(want.fields.out_level), 64'(got.out_level));
                    check_field("out_x", 64'(want.fields.out_x), 64'(got.out_x));
                    check_field("out_y", 64'(want.fields.out_y), 64'(got.out_y));
                    check_field("out_z", 64'(want.fields.out_z), 64'(got.out_z));
                    check_field("bad_item", 64'(want.rejected), 64'(i_m_tuser[0]));
                    check_field("padding", 64'(0),
                                64'(i_m_tdata[ocnic_pkg::TDATA_W-1:OUT_W]));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                conversions.insert(conversions.size(),
                                   convert_node(ocnic_pkg::t_opcode'(i_s_tuser[0]),
                                                ocnic_pkg::t_in_item'(i_s_tdata[IN_W-1:0])));
            end
        end
        o_pending_count = conversions.size();
    end

endmodule

// ===== dv/octree_node_id_codec_top_test.sv =====
// Testbench top for the octree node id codec: clock, reset, stimulus, output stalls and verdict.
// Depends on ocnic_pkg, octree_node_id_codec_top and octree_node_id_codec_checker.
module octree_node_id_codec_top_test;

    localparam int DEPTH_LIMIT  = ocnic_pkg::DEPTH_LIMIT_DEF;
    localparam int FIT_LEVEL    = ocnic_pkg::FIT_LEVEL;
    localparam int ID_W         = ocnic_pkg::ID_W;
    localparam int COORD_W      = ocnic_pkg::COORD_W;
    localparam int LEVEL_W      = ocnic_pkg::LEVEL_W;
    localparam int TDATA_W      = ocnic_pkg::TDATA_W;
    localparam int DEEPEST      = (DEPTH_LIMIT < FIT_LEVEL) ? DEPTH_LIMIT : FIT_LEVEL;
    localparam int RANDOM_ITEMS = 950;
    localparam int HOLD_CYCLES  = 200;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic [0:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [0:0]         m_tuser;

    int fail_count;
    int pending_count;
    int rejected_count;
    int n_encodes;
    int n_decodes;
    bit hold_off_req;

    octree_node_id_codec_top #(.DEPTH_LIMIT(DEPTH_LIMIT)) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser)
    );

    octree_node_id_codec_checker #(.DEPTH_LIMIT(DEPTH_LIMIT)) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tuser       (m_tuser),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count),
        .o_rejected_count(rejected_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("octree_node_id_codec_top_test: FAIL");
        $finish;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ID_W-1:0];
    endfunction

    function automatic ocnic_pkg::t_in_item rand_fields();
        ocnic_pkg::t_in_item it;
        it.level     = LEVEL_W'($urandom);
        it.coord_x   = COORD_W'($urandom);
        it.coord_y   = COORD_W'($urandom);
        it.coord_z   = COORD_W'($urandom);
        it.packed_id = rand_id();
        return it;
    endfunction

    function automatic logic [ID_W-1:0] id_with_sentinel(int pos);
        logic [ID_W-1:0] one;
        one = ID_W'(1) << pos;
        return (rand_id() & (one - ID_W'(1))) | one;
    endfunction

    task automatic offer_conversion(input ocnic_pkg::t_opcode op,
                                    input ocnic_pkg::t_in_item it, input int gap);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W-$bits(ocnic_pkg::t_in_item)){1'b0}}, it};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        if (op == ocnic_pkg::OP_ENCODE) n_encodes++;
        else n_decodes++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_location(input int lvl, input logic [COORD_W-1:0] x,
                                 input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
        ocnic_pkg::t_in_item it;
        it         = rand_fields();
        it.level   = LEVEL_W'(lvl);
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        offer_conversion(ocnic_pkg::OP_ENCODE, it, idle_gap());
    endtask

    task automatic send_node_id(input logic [ID_W-1:0] id);
        ocnic_pkg::t_in_item it;
        it           = rand_fields();
        it.packed_id = id;
        offer_conversion(ocnic_pkg::OP_DECODE, it, idle_gap());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending_count != 0);
        @(posedge clk);
    endtask

    task automatic random_conversion(input int gap);
        ocnic_pkg::t_in_item it;
        int                  pick;
        int                  pos;
        it   = rand_fields();
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            if ($urandom_range(0, 9) == 0) begin
                it.level = LEVEL_W'($urandom_range(DEPTH_LIMIT + 1, 31));
            end else begin
                it.level = LEVEL_W'($urandom_range(0, DEPTH_LIMIT));
            end
            offer_conversion(ocnic_pkg::OP_ENCODE, it, gap);
        end else begin
            if (pick < 85) begin
                it.packed_id = id_with_sentinel(3 * $urandom_range(0, DEEPEST));
            end else if (pick < 95) begin
                it.packed_id = rand_id();
            end else if (pick < 98) begin
                pos = 3 * $urandom_range(0, (ID_W - 3) / 3) + $urandom_range(1, 2);
                it.packed_id = id_with_sentinel(pos);
            end else begin
                it.packed_id = '0;
            end
            offer_conversion(ocnic_pkg::OP_DECODE, it, gap);
        end
    endtask

    initial begin : sink
        int hold_left;
        int cycle_no;
        hold_left = 0;
        cycle_no  = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            cycle_no++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (cycle_no % 1000 < 150) begin
                m_tready <= 1'b1;
            end else begin
                hold_left = idle_gap();
                m_tready <= (hold_left == 0);
                if (hold_left > 0) hold_left--;
            end
        end
    end

    initial begin : stimulus
        bit quiet;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ocnic_pkg::OP_ENCODE;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_location(0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_location(1, 16'h0001, 16'h0000, 16'h0000);
        send_location(1, 16'h0000, 16'h0001, 16'h0000);
        send_location(1, 16'h0000, 16'h0000, 16'h0001);
        send_location(4, 16'hFFF5, 16'hFFFA, 16'hFFF0);
        send_location(DEPTH_LIMIT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_location(DEPTH_LIMIT, 16'h0000, 16'h0000, 16'h0000);
        send_location(DEPTH_LIMIT, 16'hAAAA, 16'h5555, 16'hF00F);
        send_location(DEPTH_LIMIT + 1, 16'h1234, 16'h5678, 16'h9ABC);
        send_location(31, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_node_id('0);
        send_node_id(ID_W'(1));
        send_node_id(ID_W'(1) << (ID_W - 1));
        send_node_id('1);
        send_node_id(ID_W'(2));
        send_node_id(ID_W'(4));
        send_node_id(ID_W'(8) | ID_W'(5));
        send_node_id(id_with_sentinel(ID_W - 2));
        send_node_id(id_with_sentinel(ID_W - 3));
        send_node_id(id_with_sentinel(ID_W - 4));
        send_node_id(ID_W'(1) << (ID_W - 1) | ID_W'(49'h0_5555_5555_5555));
        send_node_id(ID_W'(1) << (ID_W - 1) | ID_W'(49'h0_AAAA_AAAA_AAAA));
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = (i >= 100 && i < 200) || (i >= 400 && i < 460) || (i >= 600 && i < 700);
            if (i == 400) hold_off_req = 1'b1;
            if (i == 800) wait_drained();
            random_conversion(quiet ? 0 : idle_gap());
        end

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Ran %0d encode and %0d decode items, %0d rejected by the block,",
                 n_encodes, n_decodes, rejected_count);
        $display("under back-to-back bursts, random gaps on both sides and a long output stall.");
        if (fail_count == 0 && pending_count == 0) begin
            $display("octree_node_id_codec_top_test: PASS");
        end else begin
            $display("octree_node_id_codec_top_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ocnic_pkg.sv
rtl/core/ocnic_encoder.sv
rtl/core/ocnic_decoder.sv
rtl/core/octree_node_id_codec_top.sv
dv/octree_node_id_codec_checker.sv
dv/octree_node_id_codec_top_test.sv
